/* design/c8sfd_pkg.sv */
// ----------------------------------------------------------------------------
// c8sfd_pkg: shared types and functions for the CRC-8 frame deframer
// Holds the frame phase encoding, the result record and the CRC-8 byte fold.
// ----------------------------------------------------------------------------
package c8sfd_pkg;

  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] CRC_INIT = 8'h00;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN     = 3'd1,
    PH_TYPE    = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CRC     = 3'd4
  } phase_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_END     = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t      result_kind;
    logic [7:0] frame_type;
    logic [7:0] frame_length;
    logic [7:0] payload_byte;
    logic [7:0] byte_index;
    logic       crc_ok;
    logic [7:0] computed_crc;
  } result_t;

  // Fold one byte into the CRC, MSB first, no reflection.
  function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* design/c8sfd_in_reg.sv */
// ----------------------------------------------------------------------------
// c8sfd_in_reg: input register for received bytes
// Captures one byte per transfer and holds it until the frame logic takes it.
// ----------------------------------------------------------------------------
module c8sfd_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       take,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  logic accept;

  assign in_stall = held_valid && !take;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_byte <= rx_byte;
    end
  end

endmodule

/* design/c8sfd_core.sv */
// ----------------------------------------------------------------------------
// c8sfd_core: frame phase tracking and CRC-8 accumulation
// Steps the frame state by one byte and forms the result for payload and CRC bytes.
// ----------------------------------------------------------------------------
module c8sfd_core (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         start_byte,
  input  logic               held_valid,
  input  logic [7:0]         held_byte,
  input  logic               out_free,
  output logic               take,
  output logic               res_valid,
  output c8sfd_pkg::result_t res
);

  c8sfd_pkg::phase_t phase, phase_next;
  logic [7:0] announced_length, announced_length_next;
  logic [7:0] current_type, current_type_next;
  logic [7:0] bytes_seen, bytes_seen_next;
  logic [7:0] running_crc, running_crc_next;
  logic [7:0] crc_base;
  logic [7:0] crc_folded;
  logic [7:0] seen_inc;
  logic       produces;

  assign crc_base   = (phase == c8sfd_pkg::PH_LEN) ? c8sfd_pkg::CRC_INIT : running_crc;
  assign crc_folded = c8sfd_pkg::crc_fold(crc_base, held_byte);
  assign seen_inc   = bytes_seen + 8'd1;

  assign produces  = (phase == c8sfd_pkg::PH_PAYLOAD) || (phase == c8sfd_pkg::PH_CRC);
  // Hold a result-producing byte while the result register is full and stalled.
  assign take      = held_valid && (!produces || out_free);
  assign res_valid = take && produces;

  always_comb begin
    phase_next            = phase;
    announced_length_next = announced_length;
    current_type_next     = current_type;
    bytes_seen_next       = bytes_seen;
    running_crc_next      = running_crc;
    res.result_kind       = c8sfd_pkg::KIND_PAYLOAD;
    res.frame_type        = current_type;
    res.frame_length      = announced_length;
    res.payload_byte      = held_byte;
    res.byte_index        = bytes_seen;
    res.crc_ok            = 1'b0;
    res.computed_crc      = crc_folded;
    case (phase)
      c8sfd_pkg::PH_LEN: begin
        announced_length_next = held_byte;
        running_crc_next      = crc_folded;
        phase_next            = c8sfd_pkg::PH_TYPE;
      end
      c8sfd_pkg::PH_TYPE: begin
        current_type_next = held_byte;
        running_crc_next  = crc_folded;
        bytes_seen_next   = 8'd0;
        phase_next        = (announced_length == 8'd0) ? c8sfd_pkg::PH_CRC
                                                       : c8sfd_pkg::PH_PAYLOAD;
      end
      c8sfd_pkg::PH_PAYLOAD: begin
        running_crc_next = crc_folded;
        bytes_seen_next  = seen_inc;
        if (seen_inc == announced_length) begin
          phase_next = c8sfd_pkg::PH_CRC;
        end
      end
      c8sfd_pkg::PH_CRC: begin
        res.result_kind  = c8sfd_pkg::KIND_END;
        res.payload_byte = 8'd0;
        res.byte_index   = 8'd0;
        res.crc_ok       = (held_byte == running_crc);
        res.computed_crc = running_crc;
        phase_next       = c8sfd_pkg::PH_HUNT;
      end
      default: begin
        phase_next = (held_byte == start_byte) ? c8sfd_pkg::PH_LEN : c8sfd_pkg::PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= c8sfd_pkg::PH_HUNT;
      announced_length <= 8'd0;
      current_type     <= 8'd0;
      bytes_seen       <= 8'd0;
      running_crc      <= c8sfd_pkg::CRC_INIT;
    end else if (take) begin
      phase            <= phase_next;
      announced_length <= announced_length_next;
      current_type     <= current_type_next;
      bytes_seen       <= bytes_seen_next;
      running_crc      <= running_crc_next;
    end
  end

endmodule

/* design/c8sfd_out_reg.sv */
// ----------------------------------------------------------------------------
// c8sfd_out_reg: result register
// Holds one result until the receiver takes it; refills in the same cycle.
// ----------------------------------------------------------------------------
module c8sfd_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               res_valid,
  input  c8sfd_pkg::result_t res,
  output logic               out_free,
  output logic               out_valid,
  input  logic               out_stall,
  output c8sfd_pkg::result_t out_res
);

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res <= res;
    end
  end

endmodule

/* design/crc8_serial_frame_deframer.sv */
// ----------------------------------------------------------------------------
// crc8_serial_frame_deframer: CRC-8 length-prefixed frame deframer
// Hunts for the start byte, then parses length, type, payload and CRC bytes.
// ----------------------------------------------------------------------------
// Input channel: one received byte per transfer on rx_byte (in_valid/in_stall).
// Output channel: one result per transfer (out_valid/out_stall): a payload
// result for every payload byte, and an end result with crc_ok for the CRC
// byte. Start, length and type bytes produce no result.
// Configuration: cfg_wr_en writes cfg_wr_data into the start byte register;
// write it only while no frame is in flight.
// Path: a received byte is captured in the input register; its result is then
// registered in the result register, visible on the outputs from then on.
// Throughput: one byte per cycle unless a result is held; the input register
// and the result register let a new byte enter while the last result waits.
// Reset: returns to hunting, clears the frame state and sets the start byte to
// 0xAA; both channels come out of reset empty.
// Stall: a held result blocks only the next payload or CRC byte; that byte
// then waits in the input register and in_stall rises until the result moves.
// ----------------------------------------------------------------------------
module crc8_serial_frame_deframer (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       result_kind,
  output logic [7:0] frame_type,
  output logic [7:0] frame_length,
  output logic [7:0] payload_byte,
  output logic [7:0] byte_index,
  output logic       crc_ok,
  output logic [7:0] computed_crc
);

  logic               [7:0] start_byte;
  logic               take;
  logic               held_valid;
  logic               [7:0] held_byte;
  logic               out_free;
  logic               res_valid;
  c8sfd_pkg::result_t res;
  c8sfd_pkg::result_t out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= 8'hAA;
    end else if (cfg_wr_en) begin
      start_byte <= cfg_wr_data;
    end
  end

  c8sfd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .take       (take),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  c8sfd_core u_core (
    .clk        (clk),
    .rst        (rst),
    .start_byte (start_byte),
    .held_valid (held_valid),
    .held_byte  (held_byte),
    .out_free   (out_free),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res)
  );

  c8sfd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign result_kind  = out_res.result_kind;
  assign frame_type   = out_res.frame_type;
  assign frame_length = out_res.frame_length;
  assign payload_byte = out_res.payload_byte;
  assign byte_index   = out_res.byte_index;
  assign crc_ok       = out_res.crc_ok;
  assign computed_crc = out_res.computed_crc;

endmodule

/* sim/crc8_frame_checker.sv */
// ----------------------------------------------------------------------------
// crc8_frame_checker: result predictor and scoreboard for the frame deframer
// Watches both channels and the start byte write port, tracks the frame state
// of the deframer, queues the payload and end-of-frame results each accepted
// byte should cause and compares every result transfer against the oldest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package deframer_tb_pkg;

  import c8sfd_pkg::CRC_POLY;

  // CRC-8, bit-serial: feed data MSB first into the top of the register.
  function automatic logic [7:0] crc8_fold_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ data[i];
      c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

endpackage

module crc8_frame_checker
  import c8sfd_pkg::*;
  import deframer_tb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       result_kind,
  input  logic [7:0] frame_type,
  input  logic [7:0] frame_length,
  input  logic [7:0] payload_byte,
  input  logic [7:0] byte_index,
  input  logic       crc_ok,
  input  logic [7:0] computed_crc,
  output int         fail_count,
  output int         pending,
  output logic       hunting,
  output int         payload_results,
  output int         good_frames,
  output int         bad_frames
);

  localparam int MAX_REPORTS = 30;

  phase_t     frm_phase;
  logic [7:0] sof_byte;
  logic [7:0] frm_len;
  logic [7:0] frm_type;
  logic [7:0] frm_count;
  logic [7:0] frm_crc;
  result_t    expected_results[$];

  // Advance the frame state by one received byte and queue what it causes.
  task automatic parse_rx_byte(input logic [7:0] b);
    result_t r;
    r              = '0;
    r.frame_type   = frm_type;
    r.frame_length = frm_len;
    case (frm_phase)
      PH_LEN: begin
        frm_len   = b;
        frm_crc   = crc8_fold_byte(CRC_INIT, b);
        frm_phase = PH_TYPE;
      end
      PH_TYPE: begin
        frm_type  = b;
        frm_crc   = crc8_fold_byte(frm_crc, b);
        frm_count = 8'd0;
        frm_phase = (frm_len == 8'd0) ? PH_CRC : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        frm_crc        = crc8_fold_byte(frm_crc, b);
        r.result_kind  = KIND_PAYLOAD;
        r.payload_byte = b;
        r.byte_index   = frm_count;
        r.computed_crc = frm_crc;
        expected_results.push_back(r);
        payload_results++;
        frm_count = frm_count + 8'd1;
        if (frm_count == frm_len) begin
          frm_phase = PH_CRC;
        end
      end
      PH_CRC: begin
        r.result_kind  = KIND_END;
        r.crc_ok       = (b == frm_crc);
        r.computed_crc = frm_crc;
        expected_results.push_back(r);
        if (r.crc_ok) begin
          good_frames++;
        end else begin
          bad_frames++;
        end
        frm_phase = PH_HUNT;
      end
      default: begin
        // Drop anything but the start byte while hunting.
        frm_phase = (b == sof_byte) ? PH_LEN : PH_HUNT;
      end
    endcase
  endtask

  function automatic int field_bad(input string name, input logic [7:0] exp_v,
                                   input logic [7:0] act_v);
    if (exp_v === act_v) begin
      return 0;
    end
    if (fail_count < MAX_REPORTS) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
    return 1;
  endfunction

  always @(posedge clk) begin
    result_t exp_r;
    int      errs;
    if (rst) begin
      frm_phase       = PH_HUNT;
      sof_byte        = 8'hAA;
      frm_len         = 8'd0;
      frm_type        = 8'd0;
      frm_count       = 8'd0;
      frm_crc         = CRC_INIT;
      fail_count      = 0;
      payload_results = 0;
      good_frames     = 0;
      bad_frames      = 0;
      expected_results.delete();
    end else begin
      // Check the result transfer before queueing anything from this edge.
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          if (fail_count < MAX_REPORTS) begin
            $display("%0t: result with nothing expected, actual kind %0h payload %0h crc %0h",
                     $time, result_kind, payload_byte, computed_crc);
          end
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          errs  = field_bad("result_kind", 8'(exp_r.result_kind), 8'(result_kind))
                + field_bad("frame_type", exp_r.frame_type, frame_type)
                + field_bad("frame_length", exp_r.frame_length, frame_length)
                + field_bad("payload_byte", exp_r.payload_byte, payload_byte)
                + field_bad("byte_index", exp_r.byte_index, byte_index)
                + field_bad("crc_ok", 8'(exp_r.crc_ok), 8'(crc_ok))
                + field_bad("computed_crc", exp_r.computed_crc, computed_crc);
          if (errs != 0) begin
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        parse_rx_byte(rx_byte);
      end
      if (cfg_wr_en) begin
        sof_byte = cfg_wr_data;
      end
    end
    pending = expected_results.size();
    hunting = (frm_phase == PH_HUNT);
  end

endmodule

/* sim/crc8_serial_frame_deframer_test.sv */
// ----------------------------------------------------------------------------
// crc8_serial_frame_deframer_test: testbench top for the CRC-8 frame deframer
// Drives a directed set of frames, then random frames, broken frames and line
// noise under several start byte settings, with random idling on both sides
// and one long receiver hold-off. Results are checked by crc8_frame_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module crc8_serial_frame_deframer_test;

  import c8sfd_pkg::*;
  import deframer_tb_pkg::*;

  localparam int RX_ITEMS       = 1100;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int NUM_PHASES     = 5;

  logic       clk         = 1'b0;
  logic       rst         = 1'b1;
  logic       cfg_wr_en   = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;
  logic       in_valid    = 1'b0;
  logic [7:0] rx_byte     = 8'h00;
  logic       out_stall   = 1'b0;

  logic       in_stall;
  logic       out_valid;
  logic       result_kind;
  logic [7:0] frame_type;
  logic [7:0] frame_length;
  logic [7:0] payload_byte;
  logic [7:0] byte_index;
  logic       crc_ok;
  logic [7:0] computed_crc;

  int   fail_count;
  int   pending;
  logic hunting;
  int   payload_results;
  int   good_frames;
  int   bad_frames;

  bit         sender_idle = 1'b1;
  bit         recv_idle   = 1'b1;
  bit         hold_req    = 1'b0;
  bit         hold_done   = 1'b0;
  int         bytes_sent  = 0;
  int         idle_cycles = 0;
  logic [7:0] start_value = 8'hAA;
  logic [7:0] payload_q[$];

  always #1 clk = ~clk;

  crc8_serial_frame_deframer u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_kind  (result_kind),
    .frame_type   (frame_type),
    .frame_length (frame_length),
    .payload_byte (payload_byte),
    .byte_index   (byte_index),
    .crc_ok       (crc_ok),
    .computed_crc (computed_crc)
  );

  crc8_frame_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .rx_byte         (rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .result_kind     (result_kind),
    .frame_type      (frame_type),
    .frame_length    (frame_length),
    .payload_byte    (payload_byte),
    .byte_index      (byte_index),
    .crc_ok          (crc_ok),
    .computed_crc    (computed_crc),
    .fail_count      (fail_count),
    .pending         (pending),
    .hunting         (hunting),
    .payload_results (payload_results),
    .good_frames     (good_frames),
    .bad_frames      (bad_frames)
  );

  // Watchdog: count cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, idle_cycles, pending);
      $display("FAIL crc8_serial_frame_deframer");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (recv_idle && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Offer one byte and hold it until the transfer happens.
  task automatic send_byte(input logic [7:0] b);
    if (sender_idle && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // Stop offering and wait until every expected result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_start(input logic [7:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    start_value = v;
  endtask

  // Feed filler bytes until the deframer is back to hunting.
  task automatic flush_to_hunt();
    drain();
    while (!hunting) begin
      send_byte(8'($urandom_range(0, 255)));
      drain();
    end
  endtask

  task automatic fill_payload(input int len);
    payload_q.delete();
    repeat (len) payload_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // Send a frame around payload_q; optionally corrupt the CRC or cut it short.
  task automatic send_frame(input logic [7:0] typ, input bit bad_crc, input bit cut_short);
    logic [7:0] crc;
    logic [7:0] len;
    int         keep;
    len  = 8'(payload_q.size());
    keep = cut_short ? payload_q.size() / 2 : payload_q.size();
    send_byte(start_value);
    send_byte(len);
    crc = crc8_fold_byte(CRC_INIT, len);
    if (cut_short && len == 8'd0) begin
      return;
    end
    send_byte(typ);
    crc = crc8_fold_byte(crc, typ);
    for (int i = 0; i < keep; i++) begin
      send_byte(payload_q[i]);
      crc = crc8_fold_byte(crc, payload_q[i]);
    end
    if (cut_short) begin
      return;
    end
    if (bad_crc) begin
      crc = crc ^ (8'h01 << $urandom_range(0, 7));
    end
    send_byte(crc);
  endtask

  initial begin
    logic [7:0] c;
    logic [7:0] settings[NUM_PHASES];
    logic [7:0] b;
    int         goal;
    int         pick;
    int         len;

    settings[0] = 8'hAA;
    settings[1] = 8'h00;
    settings[2] = 8'hFF;
    settings[3] = 8'($urandom_range(1, 254));
    settings[4] = 8'h7E;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed frames under the reset start byte.
    send_byte(8'h00);
    send_byte(8'hFF);
    payload_q.delete();
    send_frame(8'h5A, 1'b0, 1'b0);
    payload_q = '{8'hFF, 8'h00};
    send_frame(8'hFF, 1'b0, 1'b0);
    // Start byte as payload must not resync; CRC is corrupted too.
    payload_q = '{8'hAA};
    send_frame(8'h00, 1'b1, 1'b0);

    // Change the start byte with a frame half received.
    send_byte(8'hAA);
    send_byte(8'h03);
    drain();
    write_start(8'h55);
    c = crc8_fold_byte(CRC_INIT, 8'h03);
    send_byte(8'h00);
    c = crc8_fold_byte(c, 8'h00);
    send_byte(8'h55);
    c = crc8_fold_byte(c, 8'h55);
    send_byte(8'hAA);
    c = crc8_fold_byte(c, 8'hAA);
    send_byte(8'h01);
    c = crc8_fold_byte(c, 8'h01);
    send_byte(c);
    send_byte(8'hAA);
    payload_q.delete();
    send_frame(8'h81, 1'b0, 1'b0);

    for (int k = 0; k < NUM_PHASES; k++) begin
      flush_to_hunt();
      write_start(settings[k]);
      if (k == NUM_PHASES - 1) begin
        sender_idle = 1'b0;
        recv_idle   = 1'b0;
      end
      if (k == 1) begin
        // Long receiver hold-off while a long frame keeps coming.
        hold_req = 1'b1;
        fill_payload(80);
        send_frame(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      if (k == 2) begin
        fill_payload(255);
        send_frame(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      goal = bytes_sent + (RX_ITEMS - bytes_sent) / (NUM_PHASES - k);
      while (bytes_sent < goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          repeat ($urandom_range(1, 4)) begin
            b = 8'($urandom_range(0, 255));
            if (b == start_value) begin
              b = b ^ 8'h01;
            end
            send_byte(b);
          end
        end else begin
          len = $urandom_range(0, 99);
          if (len < 3) begin
            len = 255;
          end else if (len < 15) begin
            len = $urandom_range(9, 40);
          end else begin
            len = $urandom_range(0, 8);
          end
          fill_payload(len);
          send_frame(8'($urandom_range(0, 255)), pick >= 15 && pick < 25, pick < 15);
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Run covered %0d input transfers, %0d payload results, %0d frames (%0d bad CRC).",
             bytes_sent, payload_results, good_frames + bad_frames, bad_frames);
    $display("Start byte took six values incl. 0x00 and 0xFF; one long output hold-off.");
    if (fail_count == 0 && pending == 0) begin
      $display("PASS crc8_serial_frame_deframer");
    end else begin
      $display("FAIL crc8_serial_frame_deframer");
    end
    $finish;
  end

endmodule
